/* hw/rtl/kgn_pkg.sv */
// ----------------------------------------------------------------------------
// kgn_pkg
// shared types, constants and codes of the keypoint grid nms unit
// ----------------------------------------------------------------------------
package kgn_pkg;

  localparam int MAX_WIDTH       = 512;
  localparam int MAX_HEIGHT      = 512;
  localparam int MAX_RADIUS      = 8;
  localparam int CONF_BITS       = 16;
  localparam int COORD_W         = 9;
  localparam int DIM_W           = 10;
  localparam int RAD_W           = 4;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 16;
  localparam int DEF_MAX_POINTS  = 4096;

  localparam logic [DIM_W-1:0]     RST_WIDTH     = 10'd320;
  localparam logic [DIM_W-1:0]     RST_HEIGHT    = 10'd240;
  localparam logic [CONF_BITS-1:0] RST_THRESHOLD = 16'd1311;
  localparam logic [RAD_W-1:0]     RST_RADIUS    = 4'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH     = 2'd0,
    CFG_IMAGE_HEIGHT    = 2'd1,
    CFG_CONF_THRESHOLD  = 2'd2,
    CFG_SUPPRESS_RADIUS = 2'd3
  } kgn_cfg_idx_t;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_FETCH  = 1'b1
  } kgn_op_t;

  // one candidate record
  typedef struct packed {
    logic [CONF_BITS-1:0] conf;
    logic [COORD_W-1:0]   x;
    logic [COORD_W-1:0]   y;
  } kgn_rec_t;

  // one classified beat between front and back
  typedef struct packed {
    logic                 is_fetch;
    logic                 start;
    logic                 cand;
    logic                 last;
    kgn_rec_t             rec;
    logic [COORD_W-1:0]   wmax;
    logic [COORD_W-1:0]   hmax;
    logic [RAD_W-1:0]     rad;
  } kgn_entry_t;

  typedef struct packed {
    logic       full;
    logic       empty;
    logic [1:0] count;
  } kgn_q_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SORT_RD,
    ST_SORT_WR,
    ST_NMS_RD,
    ST_NMS_LATCH,
    ST_NMS_KRD,
    ST_NMS_KCHK,
    ST_NMS_KEEP
  } kgn_state_t;

endpackage

/* hw/rtl/keypoint_grid_nms_unit.sv */
// ----------------------------------------------------------------------------
// keypoint_grid_nms_unit
// grid non-maximum suppression of a keypoint heatmap, with fetch of results
// ----------------------------------------------------------------------------
// usage
//   in channel: one beat per cycle while the queue has room; op sample
//   carries a confidence in raster order, frame_last on the final sample;
//   op fetch asks for the next kept point. out channel: one beat per
//   fetch, no beat per sample. cfg channel: index and data, always ready,
//   written only while idle by the user; the block does not enforce it.
//   samples go at one per cycle while the queue has room. a fetch pops,
//   issuing the kept list read; read data and fetch_pend_r register, then
//   the result loads into the output register. a further fetch waits in
//   the queue until the previous result has reached the output register.
//   after frame_last the back end merge sorts the candidates, then checks
//   each against the kept points already listed; the in channel stalls
//   once the two-entry queue fills during that pass.
// reset
//   rst_n synchronous: config registers back to their defaults, no frame open,
//   no kept points. the stores need no clearing pass.
// stalls
//   a stalled result holds in the output register; the next fetch waits in
//   the queue until the register frees.
// ----------------------------------------------------------------------------
module keypoint_grid_nms_unit #(
  parameter int MAX_POINTS = kgn_pkg::DEF_MAX_POINTS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [kgn_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [kgn_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_op,
  input  logic [kgn_pkg::CONF_BITS-1:0]  in_confidence,
  input  logic                           in_frame_last,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [kgn_pkg::COORD_W-1:0]    out_point_x,
  output logic [kgn_pkg::COORD_W-1:0]    out_point_y,
  output logic [kgn_pkg::CONF_BITS-1:0]  out_point_conf,
  output logic                           out_point_valid,
  output logic                           out_point_last,
  output logic                           out_overflow
);

  // front to queue
  logic                 q_push;
  kgn_pkg::kgn_entry_t  q_push_entry;
  kgn_pkg::kgn_q_stat_t q_stat;

  // queue to back
  logic                 q_pop, q_valid;
  kgn_pkg::kgn_entry_t  q_pop_entry;

  // classification and raster position
  kgn_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_op         (in_op),
    .in_confidence (in_confidence),
    .in_frame_last (in_frame_last),
    .q_stat        (q_stat),
    .q_push        (q_push),
    .q_entry       (q_push_entry)
  );

  // decoupling queue
  kgn_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_push_entry),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_entry  (q_pop_entry),
    .stat       (q_stat)
  );

  // store, sort, suppression and fetch
  kgn_back #(
    .MAX_POINTS (MAX_POINTS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_entry         (q_pop_entry),
    .q_pop           (q_pop),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .out_point_x     (out_point_x),
    .out_point_y     (out_point_y),
    .out_point_conf  (out_point_conf),
    .out_point_valid (out_point_valid),
    .out_point_last  (out_point_last),
    .out_overflow    (out_overflow)
  );

`ifndef SYNTHESIS
  // queue never takes a beat beyond its two slots
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_push && !q_pop))
    else $error("queue overrun");

  // the last mark only rides on a real point
  a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_point_last |-> out_point_valid)
    else $error("last mark without point");

  // an empty answer carries zero fields
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_point_valid |->
      (out_point_x == '0) && (out_point_y == '0) && (out_point_conf == '0))
    else $error("empty answer with data");
`endif

endmodule

/* hw/rtl/kgn_front.sv */
// ----------------------------------------------------------------------------
// kgn_front
// config registers, raster position and threshold classification
// ----------------------------------------------------------------------------
module kgn_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [kgn_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [kgn_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_op,
  input  logic [kgn_pkg::CONF_BITS-1:0] in_confidence,
  input  logic                          in_frame_last,
  input  kgn_pkg::kgn_q_stat_t          q_stat,
  output logic                          q_push,
  output kgn_pkg::kgn_entry_t           q_entry
);

  logic [kgn_pkg::DIM_W-1:0]     width_r, height_r;
  logic [kgn_pkg::CONF_BITS-1:0] thr_r;
  logic [kgn_pkg::RAD_W-1:0]     rad_r;
  logic [kgn_pkg::COORD_W-1:0]   col_r, row_r, col_nxt, row_nxt;
  logic                          open_r, open_nxt;

  logic [kgn_pkg::DIM_W-1:0]     w_eff, h_eff, col, row, col1, row1;
  logic [kgn_pkg::RAD_W-1:0]     rad_eff;
  logic                          acc_samp;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_stat.full;
  assign q_push    = in_valid && in_ready;
  assign acc_samp  = q_push && (in_op == kgn_pkg::OP_SAMPLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= kgn_pkg::RST_WIDTH;
      height_r <= kgn_pkg::RST_HEIGHT;
      thr_r    <= kgn_pkg::RST_THRESHOLD;
      rad_r    <= kgn_pkg::RST_RADIUS;
    end else if (cfg_valid && cfg_ready) begin
      unique case (kgn_pkg::kgn_cfg_idx_t'(cfg_index))
        kgn_pkg::CFG_IMAGE_WIDTH:     width_r  <= cfg_data[kgn_pkg::DIM_W-1:0];
        kgn_pkg::CFG_IMAGE_HEIGHT:    height_r <= cfg_data[kgn_pkg::DIM_W-1:0];
        kgn_pkg::CFG_CONF_THRESHOLD:  thr_r    <= cfg_data;
        kgn_pkg::CFG_SUPPRESS_RADIUS: rad_r    <= cfg_data[kgn_pkg::RAD_W-1:0];
      endcase
    end
  end

  // clamped sizes
  always_comb begin
    if (width_r == '0) w_eff = 10'd1;
    else if (width_r > 10'(kgn_pkg::MAX_WIDTH)) w_eff = 10'(kgn_pkg::MAX_WIDTH);
    else w_eff = width_r;
    if (height_r == '0) h_eff = 10'd1;
    else if (height_r > 10'(kgn_pkg::MAX_HEIGHT)) h_eff = 10'(kgn_pkg::MAX_HEIGHT);
    else h_eff = height_r;
    rad_eff = (rad_r > 4'(kgn_pkg::MAX_RADIUS)) ? 4'(kgn_pkg::MAX_RADIUS) : rad_r;
  end

  // raster position of this beat and of the next
  always_comb begin
    col  = ({1'b0, col_r} >= w_eff) ? '0 : {1'b0, col_r};
    row  = ({1'b0, row_r} >= h_eff) ? '0 : {1'b0, row_r};
    col1 = col + 10'd1;
    row1 = row + 10'd1;
    col_nxt  = col_r;
    row_nxt  = row_r;
    open_nxt = open_r;
    if (acc_samp) begin
      open_nxt = !in_frame_last;
      if (in_frame_last) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (col1 >= w_eff) begin
        col_nxt = '0;
        row_nxt = (row1 >= h_eff) ? '0 : row1[kgn_pkg::COORD_W-1:0];
      end else begin
        col_nxt = col1[kgn_pkg::COORD_W-1:0];
        row_nxt = row[kgn_pkg::COORD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      open_r <= 1'b0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      open_r <= open_nxt;
    end
  end

  always_comb begin
    q_entry.is_fetch = (in_op == kgn_pkg::OP_FETCH);
    q_entry.start    = !open_r;
    q_entry.cand     = (in_confidence >= thr_r);
    q_entry.last     = in_frame_last;
    q_entry.rec.conf = in_confidence;
    q_entry.rec.x    = col[kgn_pkg::COORD_W-1:0];
    q_entry.rec.y    = row[kgn_pkg::COORD_W-1:0];
    q_entry.wmax     = 9'(w_eff - 10'd1);
    q_entry.hmax     = 9'(h_eff - 10'd1);
    q_entry.rad      = rad_eff;
  end

endmodule

/* hw/rtl/kgn_queue.sv */
// ----------------------------------------------------------------------------
// kgn_queue
// two-entry queue of classified beats between front and back
// ----------------------------------------------------------------------------
module kgn_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  kgn_pkg::kgn_entry_t  push_entry,
  input  logic                 pop,
  output logic                 pop_valid,
  output kgn_pkg::kgn_entry_t  pop_entry,
  output kgn_pkg::kgn_q_stat_t stat
);

  kgn_pkg::kgn_entry_t slot_r [2];
  logic                wp_r, rp_r;
  logic [1:0]          cnt_r;

  assign stat.count = cnt_r;
  assign stat.full  = (cnt_r == 2'd2);
  assign stat.empty = (cnt_r == 2'd0);
  assign pop_valid  = !stat.empty;
  assign pop_entry  = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) slot_r[wp_r] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop)  rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule

/* hw/rtl/kgn_back.sv */
// ----------------------------------------------------------------------------
// kgn_back
// candidate store, merge sort, suppression scan and fetch of kept points
// ----------------------------------------------------------------------------
module kgn_back #(
  parameter int MAX_POINTS = kgn_pkg::DEF_MAX_POINTS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  input  kgn_pkg::kgn_entry_t           q_entry,
  output logic                          q_pop,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [kgn_pkg::COORD_W-1:0]   out_point_x,
  output logic [kgn_pkg::COORD_W-1:0]   out_point_y,
  output logic [kgn_pkg::CONF_BITS-1:0] out_point_conf,
  output logic                          out_point_valid,
  output logic                          out_point_last,
  output logic                          out_overflow
);

  localparam int PTR_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W = PTR_W + 1;
  localparam int S_W   = CNT_W + 2;

  kgn_pkg::kgn_state_t state_r, state_nxt;

  logic [CNT_W-1:0] cand_cnt_r, cand_cnt_nxt, kept_cnt_r, kept_cnt_nxt;
  logic [CNT_W-1:0] fptr_r, fptr_nxt, i_r, i_nxt, j_r, j_nxt;
  logic [CNT_W-1:0] w_r, w_nxt, lo_r, lo_nxt, l_r, l_nxt, rr_r, rr_nxt, k_r, k_nxt;
  logic             ovf_r, ovf_nxt, srcb_r, srcb_nxt;
  logic [kgn_pkg::COORD_W-1:0] wmax_r, wmax_nxt, hmax_r, hmax_nxt;
  logic [kgn_pkg::RAD_W-1:0]   rad_r, rad_nxt;
  kgn_pkg::kgn_rec_t cur_r, cur_nxt;

  // memories
  kgn_pkg::kgn_rec_t mem_a [MAX_POINTS];
  kgn_pkg::kgn_rec_t mem_b [MAX_POINTS];
  kgn_pkg::kgn_rec_t mem_k [MAX_POINTS];
  kgn_pkg::kgn_rec_t a_rd0_r, a_rd1_r, b_rd0_r, b_rd1_r, k_rd_r;
  logic              a_we, b_we, k_we;
  logic [PTR_W-1:0]  a_wa, b_wa, k_wa, ra0, ra1, k_ra;
  kgn_pkg::kgn_rec_t a_wd, b_wd, k_wd;

  always_ff @(posedge clk) begin
    if (a_we) mem_a[a_wa] <= a_wd;
    a_rd0_r <= mem_a[ra0];
    a_rd1_r <= mem_a[ra1];
  end

  always_ff @(posedge clk) begin
    if (b_we) mem_b[b_wa] <= b_wd;
    b_rd0_r <= mem_b[ra0];
    b_rd1_r <= mem_b[ra1];
  end

  always_ff @(posedge clk) begin
    if (k_we) mem_k[k_wa] <= k_wd;
    k_rd_r <= mem_k[k_ra];
  end

  // sample beat bookkeeping
  logic [CNT_W-1:0] s_cnt0, s_cnt1;
  logic             s_room;
  assign s_cnt0 = q_entry.start ? '0 : cand_cnt_r;
  assign s_room = (s_cnt0 < CNT_W'(MAX_POINTS));
  assign s_cnt1 = (q_entry.cand && s_room) ? s_cnt0 + CNT_W'(1) : s_cnt0;

  // merge pass bookkeeping
  logic [S_W-1:0] n_e, lo_e, w_e, sum1, sum2, sum3, w2;
  logic [CNT_W-1:0] mid, hi, k1;
  logic             lv, rv, take_r, blk_end, pass_end, sort_done;
  kgn_pkg::kgn_rec_t rec_l, rec_r, src_rd0;

  always_comb begin
    n_e   = S_W'(cand_cnt_r);
    lo_e  = S_W'(lo_r);
    w_e   = S_W'(w_r);
    sum1  = lo_e + w_e;
    sum2  = lo_e + (w_e << 1);
    sum3  = sum2 + w_e;
    w2    = w_e << 1;
    mid   = (sum1 > n_e) ? cand_cnt_r : sum1[CNT_W-1:0];
    hi    = (sum2 > n_e) ? cand_cnt_r : sum2[CNT_W-1:0];
    lv    = (l_r < mid);
    rv    = (rr_r < hi);
    rec_l = srcb_r ? b_rd0_r : a_rd0_r;
    rec_r = srcb_r ? b_rd1_r : a_rd1_r;
    src_rd0 = rec_l;
    take_r  = rv && (!lv || (rec_r.conf > rec_l.conf));
    k1        = k_r + CNT_W'(1);
    blk_end   = (k1 == hi);
    pass_end  = blk_end && (sum2 >= n_e);
    sort_done = pass_end && (w2 >= n_e);
  end

  // window test of the kept point against the current candidate
  logic [kgn_pkg::DIM_W-1:0] kx, ky, rad_e, x0, y0, xs, ys, x1, y1;
  logic                      hit;
  always_comb begin
    kx    = {1'b0, k_rd_r.x};
    ky    = {1'b0, k_rd_r.y};
    rad_e = kgn_pkg::DIM_W'(rad_r);
    x0    = (kx >= rad_e) ? kx - rad_e : '0;
    y0    = (ky >= rad_e) ? ky - rad_e : '0;
    xs    = kx + rad_e;
    ys    = ky + rad_e;
    x1    = (xs > {1'b0, wmax_r}) ? {1'b0, wmax_r} : xs;
    y1    = (ys > {1'b0, hmax_r}) ? {1'b0, hmax_r} : ys;
    hit   = (({1'b0, cur_r.x} >= x0) && ({1'b0, cur_r.x} <= x1) &&
             ({1'b0, cur_r.y} >= y0) && ({1'b0, cur_r.y} <= y1)) ||
            ((k_rd_r.x == cur_r.x) && (k_rd_r.y == cur_r.y));
  end

  // a fetch waits while the previous one is still on its way to the output
  logic             out_free, f_has, fetch_pend_r;
  logic [CNT_W-1:0] i1, j1;
  assign out_free = (!out_valid || out_ready) && !fetch_pend_r;
  assign f_has    = (fptr_r < kept_cnt_r);
  assign i1       = i_r + CNT_W'(1);
  assign j1       = j_r + CNT_W'(1);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      kgn_pkg::ST_IDLE: begin
        if (q_valid && !q_entry.is_fetch && q_entry.last) begin
          if (s_cnt1 > CNT_W'(1))       state_nxt = kgn_pkg::ST_SORT_RD;
          else if (s_cnt1 == CNT_W'(1)) state_nxt = kgn_pkg::ST_NMS_RD;
        end
      end
      kgn_pkg::ST_SORT_RD:   state_nxt = kgn_pkg::ST_SORT_WR;
      kgn_pkg::ST_SORT_WR:   state_nxt = sort_done ? kgn_pkg::ST_NMS_RD : kgn_pkg::ST_SORT_RD;
      kgn_pkg::ST_NMS_RD:    state_nxt = kgn_pkg::ST_NMS_LATCH;
      kgn_pkg::ST_NMS_LATCH: begin
        state_nxt = (kept_cnt_r == '0) ? kgn_pkg::ST_NMS_KEEP : kgn_pkg::ST_NMS_KRD;
      end
      kgn_pkg::ST_NMS_KRD:   state_nxt = kgn_pkg::ST_NMS_KCHK;
      kgn_pkg::ST_NMS_KCHK: begin
        priority if (hit) begin
          state_nxt = (i1 == cand_cnt_r) ? kgn_pkg::ST_IDLE : kgn_pkg::ST_NMS_RD;
        end else if (j1 == kept_cnt_r) begin
          state_nxt = kgn_pkg::ST_NMS_KEEP;
        end else begin
          state_nxt = kgn_pkg::ST_NMS_KRD;
        end
      end
      kgn_pkg::ST_NMS_KEEP: begin
        state_nxt = (i1 == cand_cnt_r) ? kgn_pkg::ST_IDLE : kgn_pkg::ST_NMS_RD;
      end
      default: state_nxt = kgn_pkg::ST_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    cand_cnt_nxt = cand_cnt_r;
    kept_cnt_nxt = kept_cnt_r;
    fptr_nxt     = fptr_r;
    ovf_nxt      = ovf_r;
    srcb_nxt     = srcb_r;
    wmax_nxt     = wmax_r;
    hmax_nxt     = hmax_r;
    rad_nxt      = rad_r;
    w_nxt        = w_r;
    lo_nxt       = lo_r;
    l_nxt        = l_r;
    rr_nxt       = rr_r;
    k_nxt        = k_r;
    i_nxt        = i_r;
    j_nxt        = j_r;
    cur_nxt      = cur_r;
    q_pop        = 1'b0;
    a_we = 1'b0; a_wa = k_r[PTR_W-1:0]; a_wd = rec_l;
    b_we = 1'b0; b_wa = k_r[PTR_W-1:0]; b_wd = rec_l;
    k_we = 1'b0; k_wa = kept_cnt_r[PTR_W-1:0]; k_wd = cur_r;
    ra0  = l_r[PTR_W-1:0];
    ra1  = rr_r[PTR_W-1:0];
    k_ra = fptr_r[PTR_W-1:0];
    unique case (state_r)
      kgn_pkg::ST_IDLE: begin
        if (q_valid && (q_entry.is_fetch ? out_free : 1'b1)) begin
          q_pop = 1'b1;
          if (q_entry.is_fetch) begin
            if (f_has) fptr_nxt = fptr_r + CNT_W'(1);
          end else begin
            if (q_entry.start) begin
              kept_cnt_nxt = '0;
              fptr_nxt     = '0;
              ovf_nxt      = 1'b0;
            end
            if (q_entry.cand) begin
              if (s_room) begin
                a_we = 1'b1;
                a_wa = s_cnt0[PTR_W-1:0];
                a_wd = q_entry.rec;
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            cand_cnt_nxt = s_cnt1;
            if (q_entry.last) begin
              wmax_nxt     = q_entry.wmax;
              hmax_nxt     = q_entry.hmax;
              rad_nxt      = q_entry.rad;
              kept_cnt_nxt = '0;
              fptr_nxt     = '0;
              srcb_nxt     = 1'b0;
              w_nxt        = CNT_W'(1);
              lo_nxt       = '0;
              l_nxt        = '0;
              rr_nxt       = CNT_W'(1);
              k_nxt        = '0;
              i_nxt        = '0;
            end
          end
        end
      end
      kgn_pkg::ST_SORT_RD: begin
      end
      kgn_pkg::ST_SORT_WR: begin
        if (srcb_r) begin
          a_we = 1'b1;
          a_wd = take_r ? rec_r : rec_l;
        end else begin
          b_we = 1'b1;
          b_wd = take_r ? rec_r : rec_l;
        end
        if (take_r) rr_nxt = rr_r + CNT_W'(1);
        else        l_nxt  = l_r + CNT_W'(1);
        k_nxt = k1;
        if (blk_end) begin
          if (pass_end) begin
            srcb_nxt = !srcb_r;
            w_nxt    = w2[CNT_W-1:0];
            lo_nxt   = '0;
            l_nxt    = '0;
            k_nxt    = '0;
            rr_nxt   = (w2 > n_e) ? cand_cnt_r : w2[CNT_W-1:0];
            i_nxt    = '0;
          end else begin
            lo_nxt = sum2[CNT_W-1:0];
            l_nxt  = sum2[CNT_W-1:0];
            k_nxt  = sum2[CNT_W-1:0];
            rr_nxt = (sum3 > n_e) ? cand_cnt_r : sum3[CNT_W-1:0];
          end
        end
      end
      kgn_pkg::ST_NMS_RD: begin
        ra0 = i_r[PTR_W-1:0];
      end
      kgn_pkg::ST_NMS_LATCH: begin
        cur_nxt = src_rd0;
        j_nxt   = '0;
      end
      kgn_pkg::ST_NMS_KRD: begin
        k_ra = j_r[PTR_W-1:0];
      end
      kgn_pkg::ST_NMS_KCHK: begin
        k_ra = j_r[PTR_W-1:0];
        if (hit) i_nxt = i1;
        else     j_nxt = j1;
      end
      kgn_pkg::ST_NMS_KEEP: begin
        k_we         = 1'b1;
        kept_cnt_nxt = kept_cnt_r + CNT_W'(1);
        i_nxt        = i1;
        fptr_nxt     = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= kgn_pkg::ST_IDLE;
      cand_cnt_r <= '0;
      kept_cnt_r <= '0;
      fptr_r     <= '0;
      ovf_r      <= 1'b0;
      srcb_r     <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cand_cnt_r <= cand_cnt_nxt;
      kept_cnt_r <= kept_cnt_nxt;
      fptr_r     <= fptr_nxt;
      ovf_r      <= ovf_nxt;
      srcb_r     <= srcb_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wmax_r <= wmax_nxt;
    hmax_r <= hmax_nxt;
    rad_r  <= rad_nxt;
    w_r    <= w_nxt;
    lo_r   <= lo_nxt;
    l_r    <= l_nxt;
    rr_r   <= rr_nxt;
    k_r    <= k_nxt;
    i_r    <= i_nxt;
    j_r    <= j_nxt;
    cur_r  <= cur_nxt;
  end

  // fetch: list read at pop lands with fetch_pend_r, then the result is loaded
  logic             f_has_r, f_last_r;
  logic             out_valid_r;
  kgn_pkg::kgn_rec_t out_rec_r;
  logic             out_pv_r, out_pl_r, out_ovf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fetch_pend_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      fetch_pend_r <= q_pop && q_entry.is_fetch;
      if (fetch_pend_r)   out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_entry.is_fetch) begin
      f_has_r  <= f_has;
      f_last_r <= f_has && (fptr_r + CNT_W'(1) == kept_cnt_r);
    end
    if (fetch_pend_r) begin
      out_rec_r <= f_has_r ? k_rd_r : '0;
      out_pv_r  <= f_has_r;
      out_pl_r  <= f_last_r;
      out_ovf_r <= ovf_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_point_x     = out_rec_r.x;
  assign out_point_y     = out_rec_r.y;
  assign out_point_conf  = out_rec_r.conf;
  assign out_point_valid = out_pv_r;
  assign out_point_last  = out_pl_r;
  assign out_overflow    = out_ovf_r;

endmodule
